// File: rtl/assert_macros.svh
// assertion helpers used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

`endif

// File: rtl/gwsc_pkg.sv
`default_nettype none

package gwsc_pkg;

   localparam int WEEK_W  = 13;
   localparam int SEC_W   = 20;
   localparam int OFF_W   = 8;
   localparam int DOW_W   = 4;
   localparam int TOT_W   = 16;
   localparam int YEAR_W  = 8;
   localparam int MON_W   = 4;
   localparam int DAY_W   = 5;
   localparam int DOY_W   = 9;
   localparam int JD_W    = 10;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SECF_W  = 6;
   localparam int REMD_W  = 17;
   localparam int REMH_W  = 12;

   // depth of the split/date pipeline behind the subtract stage
   localparam int PIPE_DEPTH = 6;

   localparam logic [SEC_W-1:0]  SECS_DAY   = 20'd86400;
   localparam logic [REMD_W-1:0] SECS_HOUR  = 17'd3600;
   localparam logic [REMH_W-1:0] SECS_MIN   = 12'd60;
   localparam logic [TOT_W-1:0]  DAYS_YEAR  = 16'd365;
   localparam logic [JD_W-1:0]   DAYS_NORM  = 10'd365;
   localparam logic [JD_W-1:0]   DAYS_LEAP  = 10'd366;
   localparam logic [TOT_W-1:0]  START_OFF  = 16'd5;
   localparam logic [YEAR_W-1:0] BASE_YEAR  = 8'd80;
   localparam logic [YEAR_W-1:0] MAX_YEARS  = 8'd119;

   // reciprocals, rounded up: ceil(2^36/86400), ceil(2^28/3600),
   // ceil(2^18/60), ceil(2^25/365); exact over the value ranges used
   localparam logic [19:0] RECIP_DAY  = 20'd795365;
   localparam int          SH_DAY     = 36;
   localparam logic [16:0] RECIP_HOUR = 17'd74566;
   localparam int          SH_HOUR    = 28;
   localparam logic [12:0] RECIP_MIN  = 13'd4370;
   localparam int          SH_MIN     = 18;
   localparam logic [16:0] RECIP_YEAR = 17'd91930;
   localparam int          SH_YEAR    = 25;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SECF_W-1:0] second;
   } tod_type;

   typedef struct packed {
      logic              ok;
      logic [YEAR_W-1:0] year;
      logic [MON_W-1:0]  month;
      logic [DAY_W-1:0]  mday;
      logic [DOY_W-1:0]  yday;
   } date_type;

   // days before the start of month idx+1 (idx 0 is january)
   function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                 input logic [MON_W-1:0] idx);
      logic [DOY_W-1:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         4'd12:   base = 9'd365;
         default: base = 9'd0;
      endcase
      // leap years push everything from march on by one day
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gwsc_tod.sv
`default_nettype none

// splits seconds into day of week and time of day
module gwsc_tod (
   input  logic                          clock,
   input  logic [gwsc_pkg::SEC_W-1:0]    secs,
   output logic [gwsc_pkg::DOW_W-1:0]    dow,
   output gwsc_pkg::tod_type             tod
);

   logic [gwsc_pkg::SEC_W-1:0]    s1_ff;
   logic [gwsc_pkg::DOW_W-1:0]    dow_ff, dow_in;
   logic [gwsc_pkg::REMD_W-1:0]   remd_ff, remd_in, remd2_ff;
   logic [gwsc_pkg::HOUR_W-1:0]   hr_ff, hr_in, hr2_ff, hr3_ff;
   logic [gwsc_pkg::REMH_W-1:0]   remh_ff, remh_in, remh2_ff;
   logic [gwsc_pkg::MIN_W-1:0]    mn_ff, mn_in;
   logic [gwsc_pkg::SECF_W-1:0]   sc_in;
   gwsc_pkg::tod_type             tod_ff;

   logic [39:0] day_prod;
   logic [19:0] day_sub;
   logic [33:0] hr_prod;
   logic [16:0] hr_sub;
   logic [24:0] mn_prod;
   logic [11:0] sc_sub;

   always_comb begin
      day_prod = {20'd0, secs} * {20'd0, gwsc_pkg::RECIP_DAY};
      dow_in   = day_prod[gwsc_pkg::SH_DAY +: gwsc_pkg::DOW_W];

      day_sub  = s1_ff - ({16'd0, dow_ff} * gwsc_pkg::SECS_DAY);
      remd_in  = day_sub[gwsc_pkg::REMD_W-1:0];

      hr_prod  = {17'd0, remd_ff} * {17'd0, gwsc_pkg::RECIP_HOUR};
      hr_in    = hr_prod[gwsc_pkg::SH_HOUR +: gwsc_pkg::HOUR_W];

      hr_sub   = remd2_ff - ({12'd0, hr_ff} * gwsc_pkg::SECS_HOUR);
      remh_in  = hr_sub[gwsc_pkg::REMH_W-1:0];

      mn_prod  = {13'd0, remh_ff} * {12'd0, gwsc_pkg::RECIP_MIN};
      mn_in    = mn_prod[gwsc_pkg::SH_MIN +: gwsc_pkg::MIN_W];

      sc_sub   = remh2_ff - ({6'd0, mn_ff} * gwsc_pkg::SECS_MIN);
      sc_in    = sc_sub[gwsc_pkg::SECF_W-1:0];
   end

   always_ff @(posedge clock) begin
      s1_ff         <= secs;
      dow_ff        <= dow_in;
      remd_ff       <= remd_in;
      remd2_ff      <= remd_ff;
      hr_ff         <= hr_in;
      remh_ff       <= remh_in;
      hr2_ff        <= hr_ff;
      remh2_ff      <= remh_ff;
      mn_ff         <= mn_in;
      hr3_ff        <= hr2_ff;
      tod_ff.hour   <= hr3_ff;
      tod_ff.minute <= mn_ff;
      tod_ff.second <= sc_in;
   end

   assign dow = dow_ff;
   assign tod = tod_ff;

endmodule

`default_nettype wire

// File: rtl/gwsc_date.sv
`default_nettype none

// day count since 1980 to year, day of year, month and day of month
module gwsc_date (
   input  logic                        clock,
   input  logic [gwsc_pkg::WEEK_W-1:0] week,
   input  logic [gwsc_pkg::DOW_W-1:0]  dow,
   output gwsc_pkg::date_type          date
);

   logic [gwsc_pkg::WEEK_W-1:0] week_ff;
   logic [gwsc_pkg::TOT_W-1:0]  tot_ff, tot_in, tot2_ff;
   logic [gwsc_pkg::YEAR_W-1:0] yr_ff, yr_in, yr2_ff, yr3_ff, yr_in3;
   logic [gwsc_pkg::JD_W-1:0]   jd_ff, jd_in;
   logic [gwsc_pkg::DOY_W-1:0]  doy_ff, doy_in;
   logic                        ok_ff, ok_in;
   gwsc_pkg::date_type          date_ff, date_in;

   logic [32:0]                 yr_prod;
   logic [gwsc_pkg::TOT_W-1:0]  yr_days, jd0;
   logic [8:0]                  lead_sum;
   logic [6:0]                  lead;
   logic                        nonpos, leap;
   logic [gwsc_pkg::YEAR_W-1:0] yr_dec;
   logic [gwsc_pkg::JD_W-1:0]   jd_adj, jd_fix;
   logic [gwsc_pkg::MON_W-1:0]  cnt, mon;
   logic [gwsc_pkg::DOY_W-1:0]  mday_full;

   always_comb begin
      // days since 1 jan 1980: gps epoch is the sixth
      tot_in   = {week_ff, 3'b000} - {3'd0, week_ff} + {12'd0, dow}
                 + gwsc_pkg::START_OFF;

      yr_prod  = {17'd0, tot_ff} * {16'd0, gwsc_pkg::RECIP_YEAR};
      yr_in    = yr_prod[gwsc_pkg::SH_YEAR +: gwsc_pkg::YEAR_W];

      // prior leap days, 1980 itself counts none
      yr_days  = {8'd0, yr_ff} * gwsc_pkg::DAYS_YEAR;
      jd0      = tot2_ff - yr_days;
      lead_sum = {1'b0, yr_ff} + 9'd3;
      lead     = lead_sum[8:2];
      jd_in    = {1'b0, jd0[8:0]} + 10'd1 - {3'd0, lead};

      // roll back into the previous year when the leap days overshoot
      nonpos   = jd_ff[gwsc_pkg::JD_W-1] || (jd_ff == '0);
      yr_dec   = yr2_ff - 8'd1;
      jd_adj   = jd_ff + ((yr_dec[1:0] != 2'b00) ? gwsc_pkg::DAYS_NORM
                                                 : gwsc_pkg::DAYS_LEAP);
      yr_in3   = nonpos ? yr_dec : yr2_ff;
      jd_fix   = nonpos ? jd_adj : jd_ff;
      ok_in    = (yr_in3 <= gwsc_pkg::MAX_YEARS) && !jd_fix[gwsc_pkg::JD_W-1]
                 && (jd_fix != '0);
      doy_in   = jd_fix[gwsc_pkg::DOY_W-1:0];

      // month by parallel compare against the cumulative table
      leap = (yr3_ff[1:0] == 2'b00);
      cnt  = '0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff > gwsc_pkg::cum_days(leap, 4'(k))) begin
            cnt = cnt + 4'd1;
         end
      end
      mon       = cnt + 4'd1;
      mday_full = doy_ff - gwsc_pkg::cum_days(leap, cnt);

      date_in.ok    = ok_ff;
      date_in.year  = yr3_ff + gwsc_pkg::BASE_YEAR;
      date_in.month = mon;
      date_in.mday  = mday_full[gwsc_pkg::DAY_W-1:0];
      date_in.yday  = doy_ff;
   end

   always_ff @(posedge clock) begin
      week_ff <= week;
      tot_ff  <= tot_in;
      tot2_ff <= tot_ff;
      yr_ff   <= yr_in;
      jd_ff   <= jd_in;
      yr2_ff  <= yr_ff;
      yr3_ff  <= yr_in3;
      doy_ff  <= doy_in;
      ok_ff   <= ok_in;
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

`default_nettype wire

// File: rtl/gps_week_seconds_to_calendar_top.sv
// gps week / week seconds to utc calendar date and time of day
//
// input channel: drive req_gps_week, req_week_seconds and req_leap_offset
// with start high; a beat is taken at a rising edge where start is high
// and busy is low. busy is only high while reset is asserted, so outside
// reset one beat can be taken on every clock edge.
// result channel: rsp_strobe is high for exactly one cycle per beat, with
// valid flag, year since 1900, month, day of month, day of year, hour,
// minute and second alongside. a result is invalid (all fields zero) when
// the offset exceeds the week seconds or the date lies past 2099.
// the result for a beat passes the input register, the subtract stage, the
// split/date pipeline and the result register; throughput is one beat per
// cycle outside reset, set by the fully pipelined constant dividers
// (reciprocal multiplies, one per stage) and the parallel month compare.
// reset (synchronous) clears the beat valid pipeline; no result follows
// for beats in flight. the receiver cannot stall: results are not held.
`default_nettype none

module gps_week_seconds_to_calendar_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gwsc_pkg::WEEK_W-1:0]   req_gps_week,
   input  logic [gwsc_pkg::SEC_W-1:0]    req_week_seconds,
   input  logic [gwsc_pkg::OFF_W-1:0]    req_leap_offset,
   output logic                          rsp_strobe,
   output logic                          rsp_valid_res,
   output logic [gwsc_pkg::YEAR_W-1:0]   rsp_year_since_1900,
   output logic [gwsc_pkg::MON_W-1:0]    rsp_month,
   output logic [gwsc_pkg::DAY_W-1:0]    rsp_day_of_month,
   output logic [gwsc_pkg::DOY_W-1:0]    rsp_day_of_year,
   output logic [gwsc_pkg::HOUR_W-1:0]   rsp_hour,
   output logic [gwsc_pkg::MIN_W-1:0]    rsp_minute,
   output logic [gwsc_pkg::SECF_W-1:0]   rsp_second
);

   // input register
   logic                        a_vld_ff;
   logic [gwsc_pkg::WEEK_W-1:0] a_week_ff;
   logic [gwsc_pkg::SEC_W-1:0]  a_secs_ff;
   logic [gwsc_pkg::OFF_W-1:0]  a_off_ff;

   // subtract stage
   logic                        b_vld_ff;
   logic                        b_neg_ff, b_neg_in;
   logic [gwsc_pkg::WEEK_W-1:0] b_week_ff;
   logic [gwsc_pkg::SEC_W-1:0]  b_secs_ff, b_secs_in;
   logic [gwsc_pkg::SEC_W:0]    diff;

   // beat valid and negative flag follow the split/date pipeline
   logic [gwsc_pkg::PIPE_DEPTH-1:0] vld_pipe_ff;
   logic [gwsc_pkg::PIPE_DEPTH-1:0] neg_pipe_ff;

   logic [gwsc_pkg::DOW_W-1:0]  dow;
   gwsc_pkg::tod_type           tod;
   gwsc_pkg::date_type          date;

   // result register
   logic                          strobe_ff;
   logic                          good_in;
   logic                          valid_ff;
   logic [gwsc_pkg::YEAR_W-1:0]   year_ff;
   logic [gwsc_pkg::MON_W-1:0]    month_ff;
   logic [gwsc_pkg::DAY_W-1:0]    mday_ff;
   logic [gwsc_pkg::DOY_W-1:0]    yday_ff;
   logic [gwsc_pkg::HOUR_W-1:0]   hour_ff;
   logic [gwsc_pkg::MIN_W-1:0]    minute_ff;
   logic [gwsc_pkg::SECF_W-1:0]   second_ff;

   assign busy = reset;

   // offset comes out of the week seconds only, no borrow from the week
   always_comb begin
      diff      = {1'b0, a_secs_ff} - {13'd0, a_off_ff};
      b_neg_in  = diff[gwsc_pkg::SEC_W];
      b_secs_in = diff[gwsc_pkg::SEC_W-1:0];
      good_in   = !neg_pipe_ff[gwsc_pkg::PIPE_DEPTH-1] && date.ok;
   end

   gwsc_tod u_tod (
      .clock (clock),
      .secs  (b_secs_ff),
      .dow   (dow),
      .tod   (tod)
   );

   gwsc_date u_date (
      .clock (clock),
      .week  (b_week_ff),
      .dow   (dow),
      .date  (date)
   );

   // control: valid pipeline, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         vld_pipe_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         a_vld_ff    <= start && !busy;
         b_vld_ff    <= a_vld_ff;
         vld_pipe_ff <= {vld_pipe_ff[gwsc_pkg::PIPE_DEPTH-2:0], b_vld_ff};
         strobe_ff   <= vld_pipe_ff[gwsc_pkg::PIPE_DEPTH-1];
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      a_week_ff   <= req_gps_week;
      a_secs_ff   <= req_week_seconds;
      a_off_ff    <= req_leap_offset;
      b_neg_ff    <= b_neg_in;
      b_week_ff   <= a_week_ff;
      b_secs_ff   <= b_secs_in;
      neg_pipe_ff <= {neg_pipe_ff[gwsc_pkg::PIPE_DEPTH-2:0], b_neg_ff};
      // invalid results carry all-zero fields
      valid_ff    <= good_in;
      year_ff     <= good_in ? date.year   : '0;
      month_ff    <= good_in ? date.month  : '0;
      mday_ff     <= good_in ? date.mday   : '0;
      yday_ff     <= good_in ? date.yday   : '0;
      hour_ff     <= good_in ? tod.hour    : '0;
      minute_ff   <= good_in ? tod.minute  : '0;
      second_ff   <= good_in ? tod.second  : '0;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_valid_res       = valid_ff;
   assign rsp_year_since_1900 = year_ff;
   assign rsp_month           = month_ff;
   assign rsp_day_of_month    = mday_ff;
   assign rsp_day_of_year     = yday_ff;
   assign rsp_hour            = hour_ff;
   assign rsp_minute          = minute_ff;
   assign rsp_second          = second_ff;

endmodule

`default_nettype wire

// File: rtl/gwsc_port_chk.sv
`default_nettype none
`include "assert_macros.svh"

// port-level checks on the calendar block
module gwsc_port_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [gwsc_pkg::WEEK_W-1:0]   req_gps_week,
   input  logic [gwsc_pkg::SEC_W-1:0]    req_week_seconds,
   input  logic [gwsc_pkg::OFF_W-1:0]    req_leap_offset,
   input  logic                          rsp_strobe,
   input  logic                          rsp_valid_res,
   input  logic [gwsc_pkg::YEAR_W-1:0]   rsp_year_since_1900,
   input  logic [gwsc_pkg::MON_W-1:0]    rsp_month,
   input  logic [gwsc_pkg::DAY_W-1:0]    rsp_day_of_month,
   input  logic [gwsc_pkg::DOY_W-1:0]    rsp_day_of_year,
   input  logic [gwsc_pkg::HOUR_W-1:0]   rsp_hour,
   input  logic [gwsc_pkg::MIN_W-1:0]    rsp_minute,
   input  logic [gwsc_pkg::SECF_W-1:0]   rsp_second
);

   localparam logic [3:0] SETTLE = 4'd9;

   // edges since the last reset, saturating once the pipeline has drained
   logic [3:0] gap_ff, gap_in;
   logic       settled;
   logic       beat_in;
   logic       early_neg;
   logic       strobe_chk;
   logic       fields_zero;
   logic       fields_legal;

   always_comb begin
      gap_in       = (gap_ff == SETTLE) ? gap_ff : gap_ff + 4'd1;
      settled      = (gap_ff == SETTLE);
      beat_in      = start && !busy;
      early_neg    = beat_in && (req_week_seconds < {12'd0, req_leap_offset});
      strobe_chk   = settled && rsp_strobe;
      fields_zero  = (rsp_year_since_1900 == '0) && (rsp_month == '0)
                     && (rsp_day_of_month == '0) && (rsp_day_of_year == '0)
                     && (rsp_hour == '0) && (rsp_minute == '0) && (rsp_second == '0);
      fields_legal = (rsp_year_since_1900 >= 8'd80) && (rsp_year_since_1900 <= 8'd199)
                     && (rsp_month >= 4'd1) && (rsp_month <= 4'd12)
                     && (rsp_day_of_month >= 5'd1) && (rsp_day_of_year >= 9'd1)
                     && (rsp_day_of_year <= 9'd366) && (rsp_hour <= 5'd23)
                     && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   `ASSERT_ALWAYS(a_one_rsp_per_beat, clock, reset, !settled || (rsp_strobe == $past(beat_in, 9)))
   `ASSERT_IMPLY(a_neg_is_invalid, clock, reset, strobe_chk && $past(early_neg, 9), !rsp_valid_res)
   `ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_strobe && !rsp_valid_res, fields_zero)
   `ASSERT_IMPLY(a_valid_ranges, clock, reset, rsp_strobe && rsp_valid_res, fields_legal)

endmodule

bind gps_week_seconds_to_calendar_top gwsc_port_chk u_port_chk (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

// one calendar result as the block presents it
typedef struct packed {
   logic                         ok;
   logic [gwsc_pkg::YEAR_W-1:0]  year;
   logic [gwsc_pkg::MON_W-1:0]   month;
   logic [gwsc_pkg::DAY_W-1:0]   mday;
   logic [gwsc_pkg::DOY_W-1:0]   yday;
   logic [gwsc_pkg::HOUR_W-1:0]  hour;
   logic [gwsc_pkg::MIN_W-1:0]   minute;
   logic [gwsc_pkg::SECF_W-1:0]  second;
} cal_beat_type;

class calendar_board_type;
   cal_beat_type due_dates[$];
   int unsigned  mismatches;

   function new();
      mismatches = 0;
   endfunction

   // utc calendar date and time of day for one request
   function cal_beat_type gps_to_calendar(logic [gwsc_pkg::WEEK_W-1:0] week,
                                          logic [gwsc_pkg::SEC_W-1:0]  secs,
                                          logic [gwsc_pkg::OFF_W-1:0]  off);
      cal_beat_type res;
      int unsigned  w, s, o;
      int unsigned  utc_secs, day_of_week, hr, mn, sc, days, years, leaps, mon;
      int unsigned  yr_out, mday;
      int           jday;
      int unsigned  mon_start[13];
      res = '0;
      w   = 32'(week);
      s   = 32'(secs);
      o   = 32'(off);
      if (s < o) begin
         return res;
      end
      utc_secs    = s - o;
      day_of_week = utc_secs / 86400;
      hr          = (utc_secs % 86400) / 3600;
      mn          = (utc_secs % 3600) / 60;
      sc          = utc_secs % 60;
      // day count from 1 jan 1980; gps time starts on the 6th
      days  = w * 7 + day_of_week + 5;
      years = days / 365;
      leaps = (years + 3) / 4;
      jday  = int'(days - years * 365) + 1 - int'(leaps);
      if (jday <= 0) begin
         years = years - 1;
         jday  = jday + (((years % 4) != 0) ? 365 : 366);
      end
      if (years > 119 || jday <= 0) begin
         return res;
      end
      mon_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      if ((years % 4) == 0) begin
         for (int i = 2; i < 13; i++) begin
            mon_start[i] = mon_start[i] + 1;
         end
      end
      mon = 1;
      while (mon < 12 && jday > int'(mon_start[mon])) begin
         mon++;
      end
      yr_out     = years + 80;
      mday       = unsigned'(jday) - mon_start[mon - 1];
      res.ok     = 1'b1;
      res.year   = yr_out[gwsc_pkg::YEAR_W-1:0];
      res.month  = mon[gwsc_pkg::MON_W-1:0];
      res.mday   = mday[gwsc_pkg::DAY_W-1:0];
      res.yday   = jday[gwsc_pkg::DOY_W-1:0];
      res.hour   = hr[gwsc_pkg::HOUR_W-1:0];
      res.minute = mn[gwsc_pkg::MIN_W-1:0];
      res.second = sc[gwsc_pkg::SECF_W-1:0];
      return res;
   endfunction

   function void note_request(logic [gwsc_pkg::WEEK_W-1:0] week,
                              logic [gwsc_pkg::SEC_W-1:0]  secs,
                              logic [gwsc_pkg::OFF_W-1:0]  off);
      due_dates.push_back(gps_to_calendar(week, secs, off));
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function void check_response(cal_beat_type got);
      cal_beat_type want;
      if (due_dates.size() == 0) begin
         $display("%0t: result with nothing expected, actual %p", $time, got);
         mismatches++;
         return;
      end
      want = due_dates.pop_front();
      compare_field("valid_res", 32'(want.ok), 32'(got.ok));
      compare_field("year_since_1900", 32'(want.year), 32'(got.year));
      compare_field("month", 32'(want.month), 32'(got.month));
      compare_field("day_of_month", 32'(want.mday), 32'(got.mday));
      compare_field("day_of_year", 32'(want.yday), 32'(got.yday));
      compare_field("hour", 32'(want.hour), 32'(got.hour));
      compare_field("minute", 32'(want.minute), 32'(got.minute));
      compare_field("second", 32'(want.second), 32'(got.second));
   endfunction

   function int unsigned outstanding();
      return due_dates.size();
   endfunction
endclass

module tb;

   // drain wait after the last expected result
   localparam int DRAIN_CYCLES = 12;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [gwsc_pkg::WEEK_W-1:0]   req_gps_week = '0;
   logic [gwsc_pkg::SEC_W-1:0]    req_week_seconds = '0;
   logic [gwsc_pkg::OFF_W-1:0]    req_leap_offset = '0;
   logic                          rsp_strobe;
   logic                          rsp_valid_res;
   logic [gwsc_pkg::YEAR_W-1:0]   rsp_year_since_1900;
   logic [gwsc_pkg::MON_W-1:0]    rsp_month;
   logic [gwsc_pkg::DAY_W-1:0]    rsp_day_of_month;
   logic [gwsc_pkg::DOY_W-1:0]    rsp_day_of_year;
   logic [gwsc_pkg::HOUR_W-1:0]   rsp_hour;
   logic [gwsc_pkg::MIN_W-1:0]    rsp_minute;
   logic [gwsc_pkg::SECF_W-1:0]   rsp_second;

   calendar_board_type board = new();

   // requests left in the current stretch without idle gaps
   int unsigned quiet_left = 0;

   gps_week_seconds_to_calendar_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_gps_week        (req_gps_week),
      .req_week_seconds    (req_week_seconds),
      .req_leap_offset     (req_leap_offset),
      .rsp_strobe          (rsp_strobe),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_year_since_1900 (rsp_year_since_1900),
      .rsp_month           (rsp_month),
      .rsp_day_of_month    (rsp_day_of_month),
      .rsp_day_of_year     (rsp_day_of_year),
      .rsp_hour            (rsp_hour),
      .rsp_minute          (rsp_minute),
      .rsp_second          (rsp_second)
   );

   always #5 clock = ~clock;

   // monitor: inputs and outputs are read at the edge, before any driver update lands
   always @(posedge clock) begin : watch_ports
      cal_beat_type seen;
      // a request beat is taken when start is high and busy is low
      if (!reset && start && !busy) begin
         board.note_request(req_gps_week, req_week_seconds, req_leap_offset);
      end
      // the strobe marks a single-cycle result; there is no back-pressure
      if (!reset && rsp_strobe === 1'b1) begin
         seen.ok     = rsp_valid_res;
         seen.year   = rsp_year_since_1900;
         seen.month  = rsp_month;
         seen.mday   = rsp_day_of_month;
         seen.yday   = rsp_day_of_year;
         seen.hour   = rsp_hour;
         seen.minute = rsp_minute;
         seen.second = rsp_second;
         board.check_response(seen);
      end
   end

   // present one request and hold it until the block takes it
   task automatic send_beat(input logic [gwsc_pkg::WEEK_W-1:0] week,
                            input logic [gwsc_pkg::SEC_W-1:0]  secs,
                            input logic [gwsc_pkg::OFF_W-1:0]  off);
      start            <= 1'b1;
      req_gps_week     <= week;
      req_week_seconds <= secs;
      req_leap_offset  <= off;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // drop start for some cycles; the request fields carry noise meanwhile
   task automatic idle_requests(input int unsigned cycles);
      if (cycles == 0) begin
         return;
      end
      start            <= 1'b0;
      req_gps_week     <= 13'($urandom);
      req_week_seconds <= 20'($urandom);
      req_leap_offset  <= 8'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // mostly back-to-back, some short gaps, a few long ones, and quiet bursts
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         quiet_left = $urandom_range(60, 20);
      end
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 4);
   endfunction

   // random request, weighted toward real dates and year edges
   task automatic send_random();
      int unsigned                 kind, yr, jan1, days, dow;
      logic [gwsc_pkg::WEEK_W-1:0] week;
      logic [gwsc_pkg::SEC_W-1:0]  secs;
      logic [gwsc_pkg::OFF_W-1:0]  off;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // ordinary fix in gps weeks up to that of the 2099 limit
         week = 13'($urandom_range(6260, 0));
         secs = 20'($urandom_range(604799, 0));
         off  = 8'($urandom_range(25, 0));
      end else if (kind < 75) begin
         // land within two days of a new year, up to and past the 2099 limit
         yr   = $urandom_range(120, 0);
         jan1 = 365 * yr + (yr + 3) / 4;
         days = jan1 + $urandom_range(4, 0);
         days = (days < 7) ? 5 : days - 2;
         dow  = (days - 5) % 7;
         week = 13'((days - 5) / 7);
         off  = 8'($urandom_range(25, 0));
         secs = 20'(dow * 86400 + $urandom_range(86399, 0) + 32'(off));
      end else if (kind < 85) begin
         // offset near or above the week seconds
         week = 13'($urandom_range(8191, 0));
         secs = 20'($urandom_range(300, 0));
         off  = 8'($urandom_range(255, 0));
      end else begin
         // anything the fields can carry
         week = 13'($urandom_range(8191, 0));
         secs = 20'($urandom_range(1048575, 0));
         off  = 8'($urandom_range(255, 0));
      end
      send_beat(week, secs, off);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: first gps second, 1980-01-06 00:00:00
      send_beat(13'd0, 20'd0, 8'd0);
      // offset larger than the week seconds gives an invalid result
      send_beat(13'd0, 20'd5, 8'd6);
      send_beat(13'd4000, 20'd0, 8'd255);
      send_beat(13'd4000, 20'd254, 8'd255);
      // offset equal to the seconds is still valid
      send_beat(13'd1234, 20'd255, 8'd255);
      // last second of a day: 23:59:59
      send_beat(13'd10, 20'd86399, 8'd0);
      // last second of the week with leap offset
      send_beat(13'd2000, 20'd604799, 8'd18);
      // 31 dec 1980, day 366 of a leap year via roll-back
      send_beat(13'd51, 20'd259200, 8'd0);
      // 31 dec 1981, roll-back into a common year
      send_beat(13'd103, 20'd345600, 8'd0);
      // 29 feb 1984
      send_beat(13'd216, 20'd259200 + 20'd43210, 8'd0);
      // last valid second, 31 dec 2099 23:59:59
      send_beat(13'd6260, 20'd431999, 8'd0);
      // one second later falls past 2099
      send_beat(13'd6260, 20'd432000, 8'd0);
      send_beat(13'd6260, 20'd432017, 8'd17);
      // week seconds beyond a week carry whole days into the date
      send_beat(13'd100, 20'd1048575, 8'd0);
      send_beat(13'd6259, 20'd1048575, 8'd255);
      // top of the week range
      send_beat(13'd8191, 20'd1048575, 8'd0);
      send_beat(13'd8191, 20'd0, 8'd255);
      // alternating bit patterns on every field
      send_beat(13'h1555, 20'hAAAAA, 8'h55);
      send_beat(13'h0AAA, 20'h55555, 8'hAA);
      // early gps weeks across the 1980 year end with idle gaps
      idle_requests(3);
      send_beat(13'd52, 20'd0, 8'd1);
      idle_requests(1);
      send_beat(13'd52, 20'd0, 8'd0);

      repeat (1900) begin
         idle_requests(pick_gap());
         send_random();
      end
      idle_requests(1);

      // drain: every result must have come back, then let the pipeline settle
      while (board.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
